FILE: design/srtc_pkg.sv
// ----------------------------------------------------------------------------
// srtc_pkg: shared types and constants for the stick rate and throttle curve
// Register layout, pipeline control bundle and the fixed-point constants used
// by the axis and throttle datapaths.
// ----------------------------------------------------------------------------
package srtc_pkg;

  localparam int NUM_STAGES = 17;
  localparam int SETUP_W    = 35;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROLL_SETUP  = 3'd0,
    REG_PITCH_SETUP = 3'd1,
    REG_YAW_SETUP   = 3'd2,
    REG_THR_EXPO    = 3'd3,
    REG_THR_LIMIT   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] limit;
    logic [6:0]  expo;
    logic [7:0]  max_rate;
    logic [7:0]  center;
  } rate_setup_t;

  typedef struct packed {
    logic [7:0] expo;
    logic [6:0] pct;
  } thr_setup_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

  localparam rate_setup_t SETUP_RESET   = 35'd16760438884;
  localparam logic [7:0]  THR_EXPO_RST  = 8'd0;
  localparam logic [6:0]  THR_PCT_RST   = 7'd100;

  // Q30 arithmetic
  localparam logic [30:0] Q30_ONE  = 31'd1073741824;
  localparam logic [30:0] Q30_HALF = 31'd536870912;

  // floor(n/25) for n <= 2^28: floor(2^29/25), then one correction step
  localparam logic [24:0] DIV25_M       = 25'd21474836;
  localparam logic [6:0]  DIV100        = 7'd100;
  // exact floor(n/25) for n < 4096: ceil(2^17/25)
  localparam logic [12:0] DIV25_SMALL_M = 13'd5243;
  // rounding offsets for the expo factor (non-negative / negative numerator)
  localparam logic [13:0] EXPO_RND_POS  = 14'd49;
  localparam logic [13:0] EXPO_RND_NEG  = 14'd50;
  localparam logic [37:0] EXPO_SIGN_LIM = 38'd107374182400;

  // throttle: floor(n/6375) for n < 2^28 via floor(2^28/6375) and a correction
  localparam logic [29:0] THR_HALF      = 30'd12750;
  localparam logic [29:0] THR_CAP       = 30'd835609500;
  localparam logic [15:0] DIV6375_M     = 16'd42107;
  localparam logic [12:0] THR_DIV       = 13'd6375;
  localparam logic [15:0] THR_POS_MAX   = 16'd32767;
  localparam logic [15:0] THR_NEG_MAX   = 16'd32768;

endpackage

FILE: design/srtc_cfg.sv
// ----------------------------------------------------------------------------
// srtc_cfg: configuration register file
// Holds the three axis setups and the throttle curve settings.
// ----------------------------------------------------------------------------
module srtc_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [srtc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [srtc_pkg::SETUP_W-1:0]         cfg_wdata,
  output srtc_pkg::rate_setup_t                roll_setup,
  output srtc_pkg::rate_setup_t                pitch_setup,
  output srtc_pkg::rate_setup_t                yaw_setup,
  output srtc_pkg::thr_setup_t                 thr_setup
);
  import srtc_pkg::*;

  rate_setup_t roll_r, roll_nxt, pitch_r, pitch_nxt, yaw_r, yaw_nxt;
  thr_setup_t  thr_r, thr_nxt;

  always_comb begin
    roll_nxt  = roll_r;
    pitch_nxt = pitch_r;
    yaw_nxt   = yaw_r;
    thr_nxt   = thr_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROLL_SETUP:  roll_nxt     = rate_setup_t'(cfg_wdata);
        REG_PITCH_SETUP: pitch_nxt    = rate_setup_t'(cfg_wdata);
        REG_YAW_SETUP:   yaw_nxt      = rate_setup_t'(cfg_wdata);
        REG_THR_EXPO:    thr_nxt.expo = cfg_wdata[7:0];
        REG_THR_LIMIT:   thr_nxt.pct  = cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_r   <= SETUP_RESET;
      pitch_r  <= SETUP_RESET;
      yaw_r    <= SETUP_RESET;
      thr_r    <= '{expo: THR_EXPO_RST, pct: THR_PCT_RST};
    end else begin
      roll_r   <= roll_nxt;
      pitch_r  <= pitch_nxt;
      yaw_r    <= yaw_nxt;
      thr_r    <= thr_nxt;
    end
  end

  assign roll_setup  = roll_r;
  assign pitch_setup = pitch_r;
  assign yaw_setup   = yaw_r;
  assign thr_setup   = thr_r;

endmodule

FILE: design/srtc_ctrl.sv
// ----------------------------------------------------------------------------
// srtc_ctrl: pipeline valid tracking and stage load enables
// A stage loads when it is empty or when everything after it will move, so
// bubbles collapse while the output is stalled.
// ----------------------------------------------------------------------------
module srtc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output srtc_pkg::pipe_ctl_t ctl
);
  import srtc_pkg::*;

  logic [NUM_STAGES-1:0] v_r, v_nxt, en;

  // A stage may load unless it and every stage after it hold an item and the
  // output is stalled.
  always_comb begin
    for (int s = 0; s < NUM_STAGES; s++) begin
      en[s] = out_ready || !(&(v_r | ~({NUM_STAGES{1'b1}} << s)));
    end
  end

  always_comb begin
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int s = 1; s < NUM_STAGES; s++) begin
      v_nxt[s] = en[s] ? v_r[s-1] : v_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NUM_STAGES-1];
  assign ctl.load  = en;

endmodule

FILE: design/srtc_axis.sv
// ----------------------------------------------------------------------------
// srtc_axis: actual-rates curve for one rotation axis
// Seventeen register stages from stick to clamped rate in 1/16 deg/s.
// ----------------------------------------------------------------------------
module srtc_axis #(
  parameter int STICK_FRAC_BITS = 14
) (
  input  logic                  clk,
  input  srtc_pkg::pipe_ctl_t   ctl,
  input  srtc_pkg::rate_setup_t setup,
  input  logic signed [15:0]    stick,
  output logic signed [16:0]    rate
);
  import srtc_pkg::*;

  localparam int XW  = (STICK_FRAC_BITS + 2 > 16) ? STICK_FRAC_BITS + 2 : 16;
  localparam int AXW = STICK_FRAC_BITS + 1;
  localparam int USH = 30 - STICK_FRAC_BITS;
  localparam logic signed [XW-1:0] FULL_POS = XW'(64'd1 << STICK_FRAC_BITS);
  localparam logic signed [XW-1:0] FULL_NEG = -FULL_POS;

  logic [NUM_STAGES-1:0] ld;
  assign ld = ctl.load;

  // Stage 0: saturate and convert the magnitude to Q30.
  logic signed [XW-1:0] x_ext, x_clip;
  logic [XW-1:0]        x_mag;
  logic [30:0]          u_nxt;
  always_comb begin
    x_ext = XW'(stick);
    if (x_ext > FULL_POS) begin
      x_clip = FULL_POS;
    end else if (x_ext < FULL_NEG) begin
      x_clip = FULL_NEG;
    end else begin
      x_clip = x_ext;
    end
    x_mag = x_clip[XW-1] ? XW'(-x_clip) : XW'(x_clip);
    u_nxt = {x_mag[AXW-1:0], {USH{1'b0}}};
  end

  logic [30:0] u_p [0:11];
  logic        neg_p [0:14];
  logic [30:0] u2_p [2:9];
  logic [30:0] d_p [4:6];
  logic [30:0] edq_p [7:8];
  logic [61:0] uu_r, uu4_r;
  logic [23:0] qe_r, dq_r;
  logic [6:0]  dr_r;
  logic [13:0] edr_r, s_r;
  logic        pbig_r;
  logic signed [31:0] g_r, h_r;
  logic signed [63:0] hp_r;
  logic signed [40:0] hm_r;
  logic [38:0]        uc_r;
  logic signed [41:0] t_r;
  logic signed [49:0] t160_r;
  logic signed [18:0] rate_r;
  logic signed [16:0] out_r;

  // Tap lines carrying operands to the stage that needs them.
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      u_p[0]   <= u_nxt;
      neg_p[0] <= stick[15];
    end
    for (int s = 1; s <= 11; s++) begin
      if (ld[s]) u_p[s] <= u_p[s-1];
    end
    for (int s = 1; s <= 14; s++) begin
      if (ld[s]) neg_p[s] <= neg_p[s-1];
    end
    for (int s = 3; s <= 9; s++) begin
      if (ld[s]) u2_p[s] <= u2_p[s-1];
    end
    for (int s = 5; s <= 6; s++) begin
      if (ld[s]) d_p[s] <= d_p[s-1];
    end
    if (ld[8]) edq_p[8] <= edq_p[7];
  end

  // Stages 1 to 4: u^2 and u^4 in Q30, rounded half up, then d = 1 - u^4.
  logic [61:0] uu_rnd, uu4_rnd;
  logic [30:0] u4;
  assign uu_rnd  = uu_r + 62'(Q30_HALF);
  assign uu4_rnd = uu4_r + 62'(Q30_HALF);
  assign u4      = uu4_rnd[60:30];

  always_ff @(posedge clk) begin
    if (ld[1]) uu_r    <= 62'(u_p[0]) * 62'(u_p[0]);
    if (ld[2]) u2_p[2] <= uu_rnd[60:30];
    if (ld[3]) uu4_r   <= 62'(u2_p[2]) * 62'(u2_p[2]);
    if (ld[4]) d_p[4]  <= Q30_ONE - u4;
  end

  // Stages 5 and 6: d = q*100 + r by reciprocal and one correction.
  logic [53:0] dprod;
  logic [31:0] rem_raw;
  logic [7:0]  rem8;
  logic [23:0] dq_nxt;
  logic [6:0]  dr_nxt;
  assign dprod   = 54'(d_p[4][30:2]) * 54'(DIV25_M);
  assign rem_raw = 32'(d_p[5]) - 32'(qe_r) * 32'(DIV100);
  assign rem8    = rem_raw[7:0];
  always_comb begin
    if (rem8 >= 8'(DIV100)) begin
      dq_nxt = qe_r + 24'd1;
      dr_nxt = 7'(rem8 - 8'(DIV100));
    end else begin
      dq_nxt = qe_r;
      dr_nxt = rem8[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[5]) qe_r <= dprod[52:29];
    if (ld[6]) begin
      dq_r <= dq_nxt;
      dr_r <= dr_nxt;
    end
  end

  // Stages 7 to 9: expo factor g = 1 - e*(1-u^4)/100 in Q30, rounded away
  // from zero. The rounding offset depends on the sign of the numerator.
  logic [37:0] prod_ed;
  logic [24:0] sprod;
  logic [32:0] g_full;
  assign prod_ed = 38'(d_p[6]) * 38'(setup.expo);
  assign sprod   = 25'(s_r[13:2]) * 25'(DIV25_SMALL_M);
  assign g_full  = 33'(Q30_ONE) - 33'(edq_p[8]) - 33'(sprod[24:17]);

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      edq_p[7] <= 31'(31'(dq_r) * 31'(setup.expo));
      edr_r    <= 14'(14'(dr_r) * 14'(setup.expo));
      pbig_r   <= prod_ed > EXPO_SIGN_LIM;
    end
    if (ld[8]) s_r <= edr_r + (pbig_r ? EXPO_RND_NEG : EXPO_RND_POS);
    if (ld[9]) g_r <= $signed(g_full[31:0]);
  end

  // Stages 10 and 11: h = u^2 * g, rounded away from zero.
  logic [63:0] hmag, hsum;
  logic [30:0] hr;
  assign hmag = hp_r[63] ? 64'(-hp_r) : 64'(hp_r);
  assign hsum = hmag + 64'(Q30_HALF);
  assign hr   = hsum[60:30];

  always_ff @(posedge clk) begin
    if (ld[10]) hp_r <= 64'($signed({1'b0, u2_p[9]})) * 64'(g_r);
    if (ld[11]) h_r  <= hp_r[63] ? -$signed({1'b0, hr}) : $signed({1'b0, hr});
  end

  // Stages 12 to 14: t = u*c + h*max(0, r-c), then 160*t.
  logic [7:0] m;
  assign m = (setup.max_rate > setup.center) ? setup.max_rate - setup.center : 8'd0;

  always_ff @(posedge clk) begin
    if (ld[12]) begin
      hm_r <= 41'(h_r) * 41'($signed({1'b0, m}));
      uc_r <= 39'(u_p[11]) * 39'(setup.center);
    end
    if (ld[13]) t_r    <= 42'(hm_r) + 42'($signed({1'b0, uc_r}));
    if (ld[14]) t160_r <= (50'(t_r) <<< 7) + (50'(t_r) <<< 5);
  end

  // Stages 15 and 16: scale to 1/16 deg/s, restore the stick sign, clamp.
  logic [49:0]        tmag, rsum;
  logic [17:0]        rmag;
  logic               rneg;
  logic signed [18:0] lim_s;
  logic signed [16:0] out_nxt;
  assign tmag  = t160_r[49] ? 50'(-t160_r) : 50'(t160_r);
  assign rsum  = tmag + 50'(Q30_HALF);
  assign rmag  = rsum[47:30];
  assign rneg  = t160_r[49] ^ neg_p[14];
  assign lim_s = $signed({3'b000, setup.limit, 4'b0000});
  always_comb begin
    if (rate_r > lim_s) begin
      out_nxt = lim_s[16:0];
    end else if (rate_r < -lim_s) begin
      out_nxt = 17'(-lim_s);
    end else begin
      out_nxt = rate_r[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[15]) rate_r <= rneg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    if (ld[16]) out_r  <= out_nxt;
  end

  assign rate = out_r;

endmodule

FILE: design/srtc_thr.sv
// ----------------------------------------------------------------------------
// srtc_thr: throttle curve and scaling
// Computes x*(255*S - a*(S-|x|))*p / (25500*S) in eight stages, then carries
// the result so it lines up with the axis pipelines.
// ----------------------------------------------------------------------------
module srtc_thr #(
  parameter int STICK_FRAC_BITS = 14
) (
  input  logic                 clk,
  input  srtc_pkg::pipe_ctl_t  ctl,
  input  srtc_pkg::thr_setup_t setup,
  input  logic signed [15:0]   stick,
  output logic signed [15:0]   throttle
);
  import srtc_pkg::*;

  localparam int SBIG = (STICK_FRAC_BITS > 15) ? STICK_FRAC_BITS : 15;
  localparam int SDW  = SBIG + 2;
  localparam int PRW  = SDW + 9;
  localparam int WW   = SBIG + 8;
  localparam int NW   = 23 + WW;
  localparam int NSW  = NW - STICK_FRAC_BITS;
  localparam logic signed [SDW-1:0] S_FULL = SDW'(64'd1 << STICK_FRAC_BITS);
  localparam logic signed [PRW-1:0] W_TOP  = PRW'(64'd255 << STICK_FRAC_BITS);

  logic [NUM_STAGES-1:0] ld;
  assign ld = ctl.load;

  logic [15:0]           tax_r;
  logic                  tneg_p [0:6];
  logic signed [SDW-1:0] sdiff_r;
  logic signed [PRW-1:0] prod_r;
  logic [22:0]           axp_p [1:2];
  logic [WW-1:0]         w_r;
  logic [NW-1:0]         n_r;
  logic [29:0]           n1_r;
  logic [27:0]           nq_r;
  logic [15:0]           qe_r, q_r;
  logic signed [15:0]    res_p [7:16];

  // Stage 0: magnitude and S - |x| (may be negative beyond full deflection).
  logic [15:0] tax_nxt;
  assign tax_nxt = stick[15] ? 16'(-stick) : 16'(stick);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      tax_r     <= tax_nxt;
      tneg_p[0] <= stick[15];
      sdiff_r   <= S_FULL - $signed({{(SDW-16){1'b0}}, tax_nxt});
    end
    for (int s = 1; s <= 6; s++) begin
      if (ld[s]) tneg_p[s] <= tneg_p[s-1];
    end
  end

  // Stages 1 to 3: shaped weight w and the product |x|*p*w.
  logic signed [PRW-1:0] w_full;
  assign w_full = W_TOP - prod_r;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      prod_r   <= PRW'($signed({1'b0, setup.expo})) * PRW'(sdiff_r);
      axp_p[1] <= 23'(tax_r) * 23'(setup.pct);
    end
    if (ld[2]) begin
      w_r      <= w_full[WW-1:0];
      axp_p[2] <= axp_p[1];
    end
    if (ld[3]) n_r <= NW'(axp_p[2]) * NW'(w_r);
  end

  // Stage 4: drop the stick scale, add half the divisor, cap where the
  // quotient saturates anyway.
  logic [NSW:0] nsum;
  assign nsum = (NSW+1)'(n_r[NW-1:STICK_FRAC_BITS]) + (NSW+1)'(THR_HALF);

  // Stages 5 and 6: divide by 25500 as a shift by two and a reciprocal.
  logic [43:0] qprod;
  logic [29:0] rem_full;
  logic [13:0] rem;
  assign qprod    = 44'(n1_r[29:2]) * 44'(DIV6375_M);
  assign rem_full = 30'(nq_r) - 30'(qe_r) * 30'(THR_DIV);
  assign rem      = rem_full[13:0];

  // Stage 7: sign and saturation to the 16-bit range.
  logic signed [15:0] res_nxt;
  always_comb begin
    if (!tneg_p[6]) begin
      res_nxt = (q_r > THR_POS_MAX) ? $signed(THR_POS_MAX) : $signed(q_r);
    end else begin
      res_nxt = (q_r > THR_NEG_MAX) ? $signed(THR_NEG_MAX) : $signed(16'(16'd0 - q_r));
    end
  end

  always_ff @(posedge clk) begin
    if (ld[4]) n1_r <= (nsum > (NSW+1)'(THR_CAP)) ? THR_CAP : nsum[29:0];
    if (ld[5]) begin
      qe_r <= qprod[43:28];
      nq_r <= n1_r[29:2];
    end
    if (ld[6]) q_r <= (rem >= 14'(THR_DIV)) ? qe_r + 16'd1 : qe_r;
    if (ld[7]) res_p[7] <= res_nxt;
    for (int s = 8; s <= 16; s++) begin
      if (ld[s]) res_p[s] <= res_p[s-1];
    end
  end

  assign throttle = res_p[16];

endmodule

FILE: design/stick_rate_and_throttle_curve_top.sv
// ----------------------------------------------------------------------------
// stick_rate_and_throttle_curve_top: stick to rate setpoint and throttle
// Shapes roll, pitch and yaw sticks with the actual-rates curve and the
// throttle stick with a blended parabolic curve and percent scale.
// ----------------------------------------------------------------------------
// Usage:
// One input transaction carries the four sticks (fixed point with
// STICK_FRAC_BITS fraction bits) on in_valid/in_ready. Each one produces
// exactly one output transaction on out_valid/out_ready with the three rate
// setpoints in 1/16 deg/s and the shaped throttle in stick format.
// The datapath is a 17-stage pipeline. A new transaction can be accepted every
// cycle except while the pipeline is full and out_ready is low. The depth is
// set by the axis chain, which runs u^2, u^4, the expo factor (with a divide
// by 100), two more products and the final scale and clamp as separate
// register stages.
// When the receiver holds out_ready low, the last stage keeps its result and
// earlier stages keep filling until the pipeline is full; in_ready drops only
// then. Nothing is lost or repeated across a stall.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// register defaults. Configuration writes are taken on cfg_we and must only
// be issued while no transaction is in flight.
// ----------------------------------------------------------------------------
module stick_rate_and_throttle_curve_top #(
  parameter int STICK_FRAC_BITS = 14
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [15:0]             in_roll_stick,
  input  logic signed [15:0]             in_pitch_stick,
  input  logic signed [15:0]             in_yaw_stick,
  input  logic signed [15:0]             in_throttle_stick,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [16:0]             out_roll_rate,
  output logic signed [16:0]             out_pitch_rate,
  output logic signed [16:0]             out_yaw_rate,
  output logic signed [15:0]             out_throttle_out,
  input  logic                           cfg_we,
  input  logic [srtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srtc_pkg::SETUP_W-1:0]   cfg_wdata
);
  import srtc_pkg::*;

  rate_setup_t roll_setup, pitch_setup, yaw_setup;
  thr_setup_t  thr_setup;
  pipe_ctl_t   ctl;

  // Settings are read straight from the register file by the stages using them;
  // the user must change them only while the pipeline is empty (not enforced).
  srtc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .roll_setup  (roll_setup),
    .pitch_setup (pitch_setup),
    .yaw_setup   (yaw_setup),
    .thr_setup   (thr_setup)
  );

  // One valid bit per stage; all four datapaths share the same load enables.
  srtc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  srtc_axis #(.STICK_FRAC_BITS(STICK_FRAC_BITS)) u_roll (
    .clk   (clk),
    .ctl   (ctl),
    .setup (roll_setup),
    .stick (in_roll_stick),
    .rate  (out_roll_rate)
  );

  srtc_axis #(.STICK_FRAC_BITS(STICK_FRAC_BITS)) u_pitch (
    .clk   (clk),
    .ctl   (ctl),
    .setup (pitch_setup),
    .stick (in_pitch_stick),
    .rate  (out_pitch_rate)
  );

  srtc_axis #(.STICK_FRAC_BITS(STICK_FRAC_BITS)) u_yaw (
    .clk   (clk),
    .ctl   (ctl),
    .setup (yaw_setup),
    .stick (in_yaw_stick),
    .rate  (out_yaw_rate)
  );

  // The throttle result is ready after eight stages and rides along in
  // carry registers so it leaves together with the rates.
  srtc_thr #(.STICK_FRAC_BITS(STICK_FRAC_BITS)) u_thr (
    .clk      (clk),
    .ctl      (ctl),
    .setup    (thr_setup),
    .stick    (in_throttle_stick),
    .throttle (out_throttle_out)
  );

endmodule
